[hw/rtl/ptt_pkg.sv]
// Shared types and constants of the process tree table.
package ptt_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ENTRY_W = IDX_W + 1;
    localparam int SLOT_LIMIT = 1 << IDX_W;
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(SLOT_LIMIT);
    localparam logic [IDX_W-1:0] FREED_MAX = '1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_CREATE  = 2'd1,
        OP_DESTROY = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRE,
        S_DCHK,
        S_SWEEP,
        S_FREE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             start;
        op_t              op;
        logic [IDX_W-1:0] target;
        logic [CNT_W-1:0] count;
        logic             res_ready;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             idle;
        logic             res_valid;
        status_t          status;
        logic [IDX_W-1:0] new_index;
        logic [IDX_W-1:0] freed_count;
    } ctrl_stat_t;

endpackage

[hw/rtl/ptt_if.sv]
// Channel interfaces for requests, responses and the count register write.
interface ptt_req_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [ptt_pkg::IDX_W-1:0] target_index;

    modport source (output valid, output opcode, output target_index, input ready);
    modport sink (input valid, input opcode, input target_index, output ready);
endinterface

interface ptt_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [ptt_pkg::IDX_W-1:0] new_index;
    logic [ptt_pkg::IDX_W-1:0] freed_count;

    modport source (output valid, output status, output new_index, output freed_count,
                    input ready);
    modport sink (input valid, input status, input new_index, input freed_count,
                  output ready);
endinterface

interface ptt_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ptt_pkg::CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/ptt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ptt_ctrl.sv]
// Sequencer that scans, marks and frees slots held in the slot memory.
module ptt_ctrl #(
    parameter int SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ptt_pkg::ctrl_cmd_t cmd,
    output ptt_pkg::ctrl_stat_t stat
);
    import ptt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t            state_reg, state_next;
    logic [IW:0]       idx_reg, idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              grew_reg, grew_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [IDX_W-1:0]  freed_reg, freed_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  newidx_reg, newidx_next;
    logic [SLOTS-1:0]  vld_reg, vld_next;
    logic [SLOTS-1:0]  doom_reg, doom_next;

    logic              iss;
    logic              hit;
    logic              mark;
    logic              kill;
    logic              range_err;
    logic              idx_last;
    logic              we;
    logic [IW-1:0]     rd_addr;
    logic [ENTRY_W-1:0] ram_q;
    logic              ent_use;
    logic [IDX_W-1:0]  ent_par;
    logic [IW-1:0]     tgt_ix;
    logic [IW-1:0]     par_ix;
    logic [IW-1:0]     cur_ix;

    ptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (we),
        .waddr (chk_idx_reg),
        .wdata ({1'b1, tgt_reg}),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // An entry never written since reset or init reads as a free slot, except the root.
    assign ent_use   = vld_reg[chk_idx_reg] ? ram_q[ENTRY_W-1] : (chk_idx_reg == '0);
    assign ent_par   = vld_reg[chk_idx_reg] ? ram_q[IDX_W-1:0] : '0;
    assign tgt_ix    = tgt_reg[IW-1:0];
    assign par_ix    = ent_par[IW-1:0];
    assign cur_ix    = idx_reg[IW-1:0];
    assign range_err = CNT_W'(cmd.target) >= cmd.count;
    assign idx_last  = cur_ix == IW'(SLOTS - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    unique case (cmd.op)
                        OP_CREATE:  state_next = range_err ? S_RESP : S_CRE;
                        OP_DESTROY: state_next = range_err ? S_RESP : S_DCHK;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_CRE:
            begin
                if (hit || (!iss && !chk_vld_reg))
                begin
                    state_next = S_RESP;
                end
            end
            S_DCHK:
            begin
                state_next = ent_use ? S_SWEEP : S_RESP;
            end
            S_SWEEP:
            begin
                if (!iss && !chk_vld_reg && !grew_reg)
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (idx_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (cmd.res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        idx_next    = idx_reg;
        grew_next   = grew_reg;
        tgt_next    = tgt_reg;
        freed_next  = freed_reg;
        status_next = status_reg;
        newidx_next = newidx_reg;
        vld_next    = vld_reg;
        doom_next   = doom_reg;
        iss         = 1'b0;
        hit         = 1'b0;
        mark        = 1'b0;
        kill        = 1'b0;
        we          = 1'b0;
        rd_addr     = cur_ix;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = cmd.target[IW-1:0];
                if (cmd.start)
                begin
                    tgt_next    = cmd.target;
                    freed_next  = '0;
                    status_next = ST_OK;
                    newidx_next = '0;
                    case (cmd.op)
                        OP_INIT:
                        begin
                            vld_next = '0;
                        end
                        OP_CREATE:
                        begin
                            if (range_err)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next = (IW+1)'(1);
                            end
                        end
                        OP_DESTROY:
                        begin
                            if (range_err)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                iss = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CRE:
            begin
                iss = CNT_W'(idx_reg) < cmd.count;
                if (iss)
                begin
                    idx_next = idx_reg + (IW+1)'(1);
                end
                hit = chk_vld_reg && !ent_use;
                if (hit)
                begin
                    we                    = 1'b1;
                    vld_next[chk_idx_reg] = 1'b1;
                    newidx_next           = IDX_W'(chk_idx_reg);
                end
                else if (!iss && !chk_vld_reg)
                begin
                    status_next = ST_FULL;
                end
            end
            S_DCHK:
            begin
                if (ent_use)
                begin
                    doom_next[tgt_ix] = 1'b1;
                    idx_next          = '0;
                    grew_next         = 1'b0;
                end
            end
            S_SWEEP:
            begin
                iss = idx_reg < (IW+1)'(SLOTS);
                if (iss)
                begin
                    idx_next = idx_reg + (IW+1)'(1);
                end
                mark = chk_vld_reg && (chk_idx_reg != tgt_ix) && ent_use
                       && !doom_reg[chk_idx_reg]
                       && (CNT_W'(ent_par) < CNT_W'(SLOTS)) && doom_reg[par_ix];
                if (mark)
                begin
                    doom_next[chk_idx_reg] = 1'b1;
                    grew_next              = 1'b1;
                end
                else if (!iss && !chk_vld_reg)
                begin
                    idx_next  = '0;
                    grew_next = 1'b0;
                end
            end
            S_FREE:
            begin
                kill = doom_reg[cur_ix] && (cur_ix != tgt_ix) && (cur_ix != '0);
                if (kill)
                begin
                    vld_next[cur_ix] = 1'b0;
                    if (freed_reg != FREED_MAX)
                    begin
                        freed_next = freed_reg + IDX_W'(1);
                    end
                end
                doom_next[cur_ix] = 1'b0;
                idx_next          = idx_reg + (IW+1)'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign chk_vld_next = iss;
    assign chk_idx_next = rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            chk_vld_reg <= 1'b0;
            grew_reg    <= 1'b0;
            vld_reg     <= '0;
            doom_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            grew_reg    <= grew_next;
            vld_reg     <= vld_next;
            doom_reg    <= doom_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        tgt_reg     <= tgt_next;
        freed_reg   <= freed_next;
        status_reg  <= status_next;
        newidx_reg  <= newidx_next;
    end

    assign stat.idle        = state_reg == S_IDLE;
    assign stat.res_valid   = state_reg == S_RESP;
    assign stat.status      = status_reg;
    assign stat.new_index   = newidx_reg;
    assign stat.freed_count = freed_reg;

    // No destroy leaves marks behind for the next one.
    a_marks_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> doom_reg == '0)
        else $error("doomed marks left set while idle");

    // The target stays marked for the whole sweep so its subtree can grow.
    a_target_marked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWEEP |-> doom_reg[tgt_ix])
        else $error("destroy target not marked during sweep");

    // Create never allocates the root or a slot at or beyond the count.
    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (chk_idx_reg != '0) && (CNT_W'(chk_idx_reg) < cmd.count))
        else $error("slot allocated outside the active range");

    // The root slot keeps its entry through every destroy.
    a_root_kept: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FREE |=> vld_reg[0] == $past(vld_reg[0]))
        else $error("root slot freed by destroy");

endmodule

[hw/rtl/process_tree_table.sv]
// Top level of the process tree table: count register, sequencer and response register.
//
// The table holds min(MAX_SLOTS, 64) process slots in one memory with a single read
// port, one entry per cycle. Init, the unused opcode and an index out of range answer
// without a scan. Create scans from slot 1 for the lowest free slot below the effective
// count. Destroy reads the target and, if it is in use, sweeps the whole table at most
// once per level of the target's subtree plus one final pass, then frees the marked
// slots in one more pass over every slot. A new item is taken while the previous
// response still waits in the output register. After reset or init the table is ready
// at once: the root alone is in use.
module process_tree_table #(
    parameter int MAX_SLOTS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ptt_req_if.sink   req,
    ptt_rsp_if.source rsp,
    ptt_cfg_if.sink   cfg
);
    import ptt_pkg::*;

    localparam int SLOTS = (MAX_SLOTS < SLOT_LIMIT) ? MAX_SLOTS : SLOT_LIMIT;

    logic [CNT_W-1:0] active_count_reg;
    logic [CNT_W-1:0] eff_count;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg;
    logic [IDX_W-1:0] new_index_reg;
    logic [IDX_W-1:0] freed_count_reg;
    logic             load;
    ctrl_cmd_t        cmd;
    ctrl_stat_t       stat;

    always_comb
    begin
        if (active_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (active_count_reg > CNT_W'(SLOTS))
        begin
            eff_count = CNT_W'(SLOTS);
        end
        else
        begin
            eff_count = active_count_reg;
        end
    end

    assign cfg.ready = 1'b1;
    assign req.ready = stat.idle;

    assign cmd.start     = req.valid && stat.idle;
    assign cmd.op        = op_t'(req.opcode);
    assign cmd.target    = req.target_index;
    assign cmd.count     = eff_count;
    assign cmd.res_ready = !out_valid_reg || rsp.ready;

    ptt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    assign load = stat.res_valid && cmd.res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= COUNT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                active_count_reg <= cfg.data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg      <= stat.status;
            new_index_reg   <= stat.new_index;
            freed_count_reg <= stat.freed_count;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.new_index   = new_index_reg;
    assign rsp.freed_count = freed_count_reg;

endmodule

[verif/tb_process_tree_table.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the process tree table: directed and random create/destroy traffic.
module tb_process_tree_table;
    import ptt_pkg::*;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] target;
    } table_cmd_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] new_index;
        logic [IDX_W-1:0] freed_count;
    } table_rsp_t;

    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int RSP_HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 4500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             req_valid = 1'b0;
    logic [1:0]       req_opcode = '0;
    logic [IDX_W-1:0] req_target = '0;
    logic             rsp_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_go = 1'b0;
    logic        rsp_hold = 1'b0;
    int unsigned mismatch_count = 0;

    table_cmd_t pending_cmds [$];
    table_rsp_t expected_rsp [$];
    table_cmd_t issue_cmd;

    logic [CNT_W-1:0] count_reg = COUNT_RESET;
    logic             slot_used [SLOT_LIMIT];
    logic [IDX_W-1:0] slot_parent [SLOT_LIMIT];

    logic [CNT_W-1:0] phase_counts [RANDOM_PHASES] =
        '{7'd64, 7'd5, 7'd127, 7'd1, 7'd40, 7'd0, 7'd64, 7'd2, 7'd100};

    ptt_req_if req_ch ();
    ptt_rsp_if rsp_ch ();
    ptt_cfg_if cfg_ch ();

    assign req_ch.valid = req_valid;
    assign req_ch.opcode = req_opcode;
    assign req_ch.target_index = req_target;
    assign rsp_ch.ready = rsp_ready;
    assign cfg_ch.valid = cfg_valid;
    assign cfg_ch.data = cfg_data;

    process_tree_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned effective_count(logic [CNT_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > SLOT_LIMIT)
            return SLOT_LIMIT;
        return value;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOT_LIMIT; i++)
        begin
            slot_used[i] = 1'b0;
            slot_parent[i] = '0;
        end
        slot_used[0] = 1'b1;
    endfunction

    function automatic table_rsp_t apply_command(table_cmd_t cmd);
        table_rsp_t             rsp;
        int unsigned            cnt;
        int unsigned            freed;
        int unsigned            pass;
        logic [SLOT_LIMIT-1:0]  doomed;
        logic                   grew;
        rsp = '0;
        freed = 0;
        cnt = effective_count(count_reg);
        case (cmd.op)
            OP_INIT: clear_table();
            OP_CREATE:
                if (cmd.target >= cnt)
                    rsp.status = ST_RANGE;
                else
                begin
                    rsp.status = ST_FULL;
                    for (int i = 1; i < cnt && rsp.status != ST_OK; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            slot_used[i] = 1'b1;
                            slot_parent[i] = cmd.target;
                            rsp.new_index = IDX_W'(i);
                            rsp.status = ST_OK;
                        end
                    end
                end
            OP_DESTROY:
                if (cmd.target >= cnt)
                    rsp.status = ST_RANGE;
                else if (slot_used[cmd.target])
                begin
                    doomed = '0;
                    doomed[cmd.target] = 1'b1;
                    grew = 1'b1;
                    for (pass = 0; pass < SLOT_LIMIT && grew; pass++)
                    begin
                        grew = 1'b0;
                        for (int i = 0; i < SLOT_LIMIT; i++)
                        begin
                            if (i != cmd.target && slot_used[i] && !doomed[i] &&
                                doomed[slot_parent[i]])
                            begin
                                doomed[i] = 1'b1;
                                grew = 1'b1;
                            end
                        end
                    end
                    for (int i = 1; i < SLOT_LIMIT; i++)
                    begin
                        if (i != cmd.target && doomed[i])
                        begin
                            slot_used[i] = 1'b0;
                            slot_parent[i] = '0;
                            freed++;
                        end
                    end
                    rsp.freed_count = (freed > FREED_MAX) ? FREED_MAX : IDX_W'(freed);
                end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic table_cmd_t random_cmd(int unsigned cnt);
        table_cmd_t  cmd;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        cmd.target = IDX_W'($urandom_range(0, cnt - 1));
        if (pick < 3)
            cmd.op = OP_INIT;
        else if (pick < 6)
            cmd.op = OP_NONE;
        else if (pick < 55)
            cmd.op = OP_CREATE;
        else
            cmd.op = OP_DESTROY;
        if (pick < 6 || pick % 8 == 0)
            cmd.target = IDX_W'($urandom_range(0, SLOT_LIMIT - 1));
        return cmd;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic push_cmd(input op_t op, input int unsigned target);
        table_cmd_t cmd;
        cmd.op = op;
        cmd.target = IDX_W'(target);
        pending_cmds.push_back(cmd);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        count_reg = value;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_ch.ready)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                issue_cmd = pending_cmds.pop_front();
                req_valid <= 1'b1;
                req_opcode <= issue_cmd.op;
                req_target <= issue_cmd.target;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        wait (hold_go);
        rsp_hold = 1'b1;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
        rsp_hold = 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        table_cmd_t accepted;
        table_rsp_t want;
        if (!rst_n)
            clear_table();
        else
        begin
            if (req_valid && req_ch.ready)
            begin
                accepted.op = op_t'(req_opcode);
                accepted.target = req_target;
                expected_rsp.push_back(apply_command(accepted));
            end
            if (rsp_ch.valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("item arrived with nothing expected");
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                            rsp_ch.status, want.status));
                    if (rsp_ch.new_index !== want.new_index)
                        report_mismatch($sformatf("new_index got %0d expected %0d",
                            rsp_ch.new_index, want.new_index));
                    if (rsp_ch.freed_count !== want.freed_count)
                        report_mismatch($sformatf("freed_count got %0d expected %0d",
                            rsp_ch.freed_count, want.freed_count));
                end
            end
        end
    end

    initial
    begin
        #1_000_000_000;
        $display("tb_process_tree_table failed");
        $finish;
    end

    initial
    begin
        int unsigned cnt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 26;
        recv_idle_pct = 73;

        write_count(7'd64);
        push_cmd(OP_CREATE, 0);
        push_cmd(OP_CREATE, 1);
        push_cmd(OP_CREATE, 2);
        push_cmd(OP_CREATE, 63);
        push_cmd(OP_DESTROY, 63);
        push_cmd(OP_DESTROY, 1);
        push_cmd(OP_NONE, 63);
        push_cmd(OP_CREATE, 0);
        push_cmd(OP_DESTROY, 0);
        push_cmd(OP_INIT, 63);
        push_cmd(OP_CREATE, 5);
        push_cmd(OP_CREATE, 1);
        push_cmd(OP_CREATE, 2);
        push_cmd(OP_CREATE, 3);
        push_cmd(OP_CREATE, 4);
        push_cmd(OP_DESTROY, 0);
        push_cmd(OP_DESTROY, 3);
        push_cmd(OP_INIT, 0);
        wait_drained();

        write_count(7'd2);
        push_cmd(OP_CREATE, 2);
        push_cmd(OP_DESTROY, 63);
        push_cmd(OP_CREATE, 1);
        push_cmd(OP_CREATE, 0);
        wait_drained();

        write_count(7'd0);
        push_cmd(OP_CREATE, 0);
        push_cmd(OP_CREATE, 1);
        wait_drained();

        // A full-depth chain fills the table and is then destroyed from the root.
        write_count(7'd127);
        push_cmd(OP_INIT, 0);
        for (int k = 0; k < SLOT_LIMIT - 1; k++)
            push_cmd(OP_CREATE, k);
        push_cmd(OP_CREATE, 0);
        push_cmd(OP_DESTROY, 0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 73;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_count(phase_counts[phase]);
            cnt = effective_count(phase_counts[phase]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                pending_cmds.push_back(random_cmd(cnt));
            if (phase == 6)
                hold_go = 1'b1;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
            report_mismatch("items still expected at the end");
        if (mismatch_count == 0)
            $display("tb_process_tree_table passed");
        else
            $display("tb_process_tree_table failed");
        $finish;
    end

endmodule
